### rtl/sd_card_init_and_read_sequencer_macros.svh
// ----------------------------------------------------------------------------
// SD card sequencer assertion macros
// Concurrent assertion shorthands shared by the sequencer RTL files.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_INIT_AND_READ_SEQUENCER_MACROS_SVH
`define SD_CARD_INIT_AND_READ_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdi: same-cycle check failed");
// next-cycle implication
`define SDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdi: next-cycle check failed");
`else
`define SDI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SDI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// SD card sequencer package
// Shared types, codes, constants and CSD lookup tables.
// ----------------------------------------------------------------------------
package sdi_pkg;

    // data block size and its shift
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_WINDOW = 1'd1;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd100;
    localparam logic [31:0] HOST_WINDOW_RST = 32'h00FF_8000;

    // event codes
    localparam logic [1:0] OP_DETECT   = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_ACK      = 2'd3;

    // result codes
    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_FAIL   = 2'd1;
    localparam logic [1:0] RES_ISSUED = 2'd2;

    // card status codes
    localparam logic [1:0] CARD_NONE     = 2'd0;
    localparam logic [1:0] CARD_NEW      = 2'd1;
    localparam logic [1:0] CARD_INSERTED = 2'd2;

    // response kinds
    localparam logic [2:0] RSP_NONE = 3'd0;
    localparam logic [2:0] RSP_R1   = 3'd1;
    localparam logic [2:0] RSP_R1B  = 3'd2;
    localparam logic [2:0] RSP_R2   = 3'd3;
    localparam logic [2:0] RSP_R3   = 3'd4;
    localparam logic [2:0] RSP_R6   = 3'd5;
    localparam logic [2:0] RSP_R7   = 3'd6;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] CMD_BLOCKLEN    = 6'd16;
    localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
    localparam logic [5:0] CMD_SD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP_CMD     = 6'd55;

    // protocol constants
    localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
    localparam logic [7:0]  IF_COND_ECHO  = 8'hAA;
    localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
    localparam logic [7:0]  TAAC_CSD_V2   = 8'h0E;
    localparam logic [31:0] CSD_V2_TMO_NS = 32'd250_000_000;
    localparam int          CSD_V2_SHIFT  = $clog2(1024);

    // input item
    typedef struct packed {
        logic [1:0]  op;
        logic        card_present;
        logic        command_error;
        logic [31:0] response_word0;
        logic [31:0] response_word1;
        logic [31:0] response_word2;
        logic [31:0] response_word3;
        logic [31:0] block_start;
        logic [31:0] block_count;
    } t_item;

    // command request
    typedef struct packed {
        logic        issue;
        logic [5:0]  index;
        logic [31:0] arg;
        logic [2:0]  kind;
        logic        rd;
        logic [40:0] bytes;
    } t_cmd;

    // result item
    typedef struct packed {
        t_cmd        cmd;
        logic        power_enable;
        logic        clock_enable;
        logic [1:0]  card_status;
        logic [1:0]  result_code;
        logic [35:0] sector_count;
        logic [31:0] access_timeout_ns;
    } t_result;

    // CSD decode outcome
    typedef struct packed {
        logic [35:0] sectors;
        logic [31:0] timeout_ns;
    } t_csd;

    // TAAC time unit divided by ten, for unit codes one and up
    function automatic logic [19:0] f_unit_div10(input logic [2:0] code);
        logic [19:0] v;
        case (code)
            3'd1:    v = 20'd1;
            3'd2:    v = 20'd10;
            3'd3:    v = 20'd100;
            3'd4:    v = 20'd1000;
            3'd5:    v = 20'd10000;
            3'd6:    v = 20'd100000;
            3'd7:    v = 20'd1000000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // TAAC time value, times ten
    function automatic logic [6:0] f_taac_value(input logic [3:0] code);
        logic [6:0] v;
        case (code)
            4'd0:    v = 7'd1;
            4'd1:    v = 7'd10;
            4'd2:    v = 7'd12;
            4'd3:    v = 7'd13;
            4'd4:    v = 7'd15;
            4'd5:    v = 7'd20;
            4'd6:    v = 7'd25;
            4'd7:    v = 7'd30;
            4'd8:    v = 7'd35;
            4'd9:    v = 7'd40;
            4'd10:   v = 7'd45;
            4'd11:   v = 7'd50;
            4'd12:   v = 7'd55;
            4'd13:   v = 7'd60;
            4'd14:   v = 7'd70;
            default: v = 7'd80;
        endcase
        return v;
    endfunction

    // TAAC time value over ten, truncated (nanosecond unit)
    function automatic logic [3:0] f_taac_value_div10(input logic [3:0] code);
        logic [3:0] v;
        case (code)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd1;
            4'd3:    v = 4'd1;
            4'd4:    v = 4'd1;
            4'd5:    v = 4'd2;
            4'd6:    v = 4'd2;
            4'd7:    v = 4'd3;
            4'd8:    v = 4'd3;
            4'd9:    v = 4'd4;
            4'd10:   v = 4'd4;
            4'd11:   v = 4'd5;
            4'd12:   v = 4'd5;
            4'd13:   v = 4'd6;
            4'd14:   v = 4'd7;
            default: v = 4'd8;
        endcase
        return v;
    endfunction

endpackage

### rtl/sd_card_init_and_read_sequencer.sv
// ----------------------------------------------------------------------------
// SD card init and read sequencer
// Top level: input register, step core and output register.
// ----------------------------------------------------------------------------
// Each accepted event (detect, command completion, read request, acknowledge)
// yields exactly one result: the command to send next, if any, with the bus
// power and clock requests, card status, result code and the decoded capacity
// and access timeout. An event is captured in an input register and stepped
// through combinational logic into the output register when that register
// is free, so one event per clock is sustained while the result channel does
// not stall. Configuration writes take effect at once and belong to idle time.
// ----------------------------------------------------------------------------
`include "sd_card_init_and_read_sequencer_macros.svh"

module sd_card_init_and_read_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sdi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // event channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic                              i_card_present,
    input  logic                              i_command_error,
    input  logic [31:0]                       i_response_word0,
    input  logic [31:0]                       i_response_word1,
    input  logic [31:0]                       i_response_word2,
    input  logic [31:0]                       i_response_word3,
    input  logic [31:0]                       i_block_start,
    input  logic [31:0]                       i_block_count,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_issue_command,
    output logic [5:0]                        o_command_index,
    output logic [31:0]                       o_command_argument,
    output logic [2:0]                        o_response_kind,
    output logic                              o_read_transfer,
    output logic [40:0]                       o_transfer_bytes,
    output logic                              o_power_enable,
    output logic                              o_clock_enable,
    output logic [1:0]                        o_card_status,
    output logic [1:0]                        o_result_code,
    output logic [35:0]                       o_sector_count,
    output logic [31:0]                       o_access_timeout_ns
);
    import sdi_pkg::*;

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result step_result;
    logic    out_free;
    logic    fire;
    logic    in_accept;

    // handshake: the output register frees the step whenever it drains
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op             <= i_op;
            r_in.card_present   <= i_card_present;
            r_in.command_error  <= i_command_error;
            r_in.response_word0 <= i_response_word0;
            r_in.response_word1 <= i_response_word1;
            r_in.response_word2 <= i_response_word2;
            r_in.response_word3 <= i_response_word3;
            r_in.block_start    <= i_block_start;
            r_in.block_count    <= i_block_count;
        end
    end

    sdi_seq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (r_in),
        .o_result    (step_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_issue_command     = r_out.cmd.issue;
    assign o_command_index     = r_out.cmd.index;
    assign o_command_argument  = r_out.cmd.arg;
    assign o_response_kind     = r_out.cmd.kind;
    assign o_read_transfer     = r_out.cmd.rd;
    assign o_transfer_bytes    = r_out.cmd.bytes;
    assign o_power_enable      = r_out.power_enable;
    assign o_clock_enable      = r_out.clock_enable;
    assign o_card_status       = r_out.card_status;
    assign o_result_code       = r_out.result_code;
    assign o_sector_count      = r_out.sector_count;
    assign o_access_timeout_ns = r_out.access_timeout_ns;

    // an empty input stage never pushes back
    `SDI_ASSERT_IMPL(a_no_idle_stall, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    // a stepped item always lands in the output register
    `SDI_ASSERT_NEXT(a_fire_lands, i_clk, i_rst_n, fire, r_out_valid)
    // issued result code goes with an issued command and nothing else
    `SDI_ASSERT_IMPL(a_issue_code, i_clk, i_rst_n, r_out_valid,
        (o_result_code == RES_ISSUED) == o_issue_command)
    // without a command, the command fields are clear
    `SDI_ASSERT_IMPL(a_idle_cmd_clear, i_clk, i_rst_n, r_out_valid && !o_issue_command,
        o_command_index == 6'd0 && o_command_argument == 32'd0 && !o_read_transfer)

endmodule

### rtl/sdi_csd_decode.sv
// ----------------------------------------------------------------------------
// SD card sequencer CSD decoder
// Decodes sector count and access timeout from a CSD v1 or v2 response.
// ----------------------------------------------------------------------------
module sdi_csd_decode (
    input  logic [31:0]    i_word1,
    input  logic [31:0]    i_word2,
    input  logic [31:0]    i_word3,
    output sdi_pkg::t_csd  o_csd
);
    import sdi_pkg::*;

    logic [7:0]  taac;
    logic [3:0]  blk_len_code;
    logic [12:0] c_size_p1;
    logic [2:0]  size_mult;
    logic [4:0]  v1_shift;
    logic [36:0] v1_bytes;
    logic [24:0] v2_size_p1;
    logic [35:0] v2_sectors;
    logic [26:0] v1_tmo;

    // response bytes: byte 13 = TAAC, 9 = block length, 8..6 = C_SIZE, 5..4 = mult
    assign taac         = i_word3[15:8];
    assign blk_len_code = i_word2[11:8];
    assign c_size_p1    = {1'b0, i_word2[1:0], i_word1[31:24], i_word1[23:22]} + 13'd1;
    assign size_mult    = {i_word1[9:8], i_word1[7]};

    // v1 size: (c_size+1) << (mult+2+bl_len), then over the block size
    assign v1_shift = 5'd2 + {2'b0, size_mult} + {1'b0, blk_len_code};
    assign v1_bytes = {24'd0, c_size_p1} << v1_shift;

    // v2 size: (c_size+1) * 1024
    assign v2_size_p1 = {1'b0, i_word1[31:8]} + 25'd1;
    assign v2_sectors = {1'b0, v2_size_p1, {CSD_V2_SHIFT{1'b0}}};

    // v1 timeout: unit * value / 10
    assign v1_tmo = (taac[2:0] == 3'd0)
                  ? {23'd0, f_taac_value_div10(taac[6:3])}
                  : {7'd0, f_unit_div10(taac[2:0])} * {20'd0, f_taac_value(taac[6:3])};

    always_comb begin
        if (taac == TAAC_CSD_V2) begin
            o_csd.sectors    = v2_sectors;
            o_csd.timeout_ns = CSD_V2_TMO_NS;
        end else begin
            o_csd.sectors    = {{(36 - (37 - BLOCK_SHIFT)){1'b0}}, v1_bytes[36:BLOCK_SHIFT]};
            o_csd.timeout_ns = {5'd0, v1_tmo};
        end
    end

endmodule

### rtl/sdi_seq_core.sv
// ----------------------------------------------------------------------------
// SD card sequencer step core
// Holds the card state and the configuration, and computes one step per item.
// ----------------------------------------------------------------------------
`include "sd_card_init_and_read_sequencer_macros.svh"

module sdi_seq_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_fire,
    input  sdi_pkg::t_item                    i_item,
    output sdi_pkg::t_result                  o_result
);
    import sdi_pkg::*;

    // sequence phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_GO_IDLE  = 4'd1;
    localparam logic [3:0] PH_IF_COND  = 4'd2;
    localparam logic [3:0] PH_APP_CMD  = 4'd3;
    localparam logic [3:0] PH_OP_COND  = 4'd4;
    localparam logic [3:0] PH_CID      = 4'd5;
    localparam logic [3:0] PH_RCA      = 4'd6;
    localparam logic [3:0] PH_CSD      = 4'd7;
    localparam logic [3:0] PH_SEL_INIT = 4'd8;
    localparam logic [3:0] PH_BLOCKLEN = 4'd9;
    localparam logic [3:0] PH_SEL_READ = 4'd10;
    localparam logic [3:0] PH_READ     = 4'd11;

    // configuration
    logic [7:0]  r_retry_limit;
    logic [31:0] r_host_window;

    // card state
    logic [3:0]  r_phase,        n_phase;
    logic [7:0]  r_tries,        n_tries;
    logic [31:0] r_req_ocr,      n_req_ocr;
    logic        r_high_cap,     n_high_cap;
    logic        r_inserted,     n_inserted;
    logic        r_selected,     n_selected;
    logic        r_card_unacked, n_card_unacked;
    logic [15:0] r_rca,          n_rca;
    logic [35:0] r_sectors,      n_sectors;
    logic [31:0] r_timeout,      n_timeout;
    logic [31:0] r_pend_start,   n_pend_start;
    logic [31:0] r_pend_count,   n_pend_count;
    logic        r_power,        n_power;
    logic        r_clock,        n_clock;

    t_csd csd;

    sdi_csd_decode u_csd (
        .i_word1 (i_item.response_word1),
        .i_word2 (i_item.response_word2),
        .i_word3 (i_item.response_word3),
        .o_csd   (csd)
    );

    function automatic t_cmd f_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                   input logic [2:0] kind);
        t_cmd c;
        c       = '0;
        c.issue = 1'b1;
        c.index = idx;
        c.arg   = arg;
        c.kind  = kind;
        return c;
    endfunction

    // multi-block read; byte-addressed cards take start * block size
    function automatic t_cmd f_read_cmd(input logic [31:0] start, input logic [31:0] count,
                                        input logic hc);
        t_cmd c;
        c       = f_cmd(CMD_READ_MULTI, hc ? start : {start[31-BLOCK_SHIFT:0],
                        {BLOCK_SHIFT{1'b0}}}, RSP_R1);
        c.rd    = 1'b1;
        c.bytes = {count, {BLOCK_SHIFT{1'b0}}};
        return c;
    endfunction

    // one step of the sequence
    always_comb begin
        t_cmd       cmd;
        logic [1:0] res;
        logic [7:0] tries_dec;

        cmd            = '0;
        res            = RES_OK;
        tries_dec      = r_tries - 8'd1;
        n_phase        = r_phase;
        n_tries        = r_tries;
        n_req_ocr      = r_req_ocr;
        n_high_cap     = r_high_cap;
        n_inserted     = r_inserted;
        n_selected     = r_selected;
        n_card_unacked = r_card_unacked;
        n_rca          = r_rca;
        n_sectors      = r_sectors;
        n_timeout      = r_timeout;
        n_pend_start   = r_pend_start;
        n_pend_count   = r_pend_count;
        n_power        = r_power;
        n_clock        = r_clock;

        case (i_item.op)
            OP_DETECT: begin
                n_power        = 1'b0;
                n_clock        = 1'b0;
                n_card_unacked = 1'b1;
                n_phase        = PH_IDLE;
                if (!i_item.card_present) begin
                    n_inserted = 1'b0;
                end else begin
                    n_power = 1'b1;
                    n_clock = 1'b1;
                    cmd     = f_cmd(CMD_GO_IDLE, 32'd0, RSP_NONE);
                    n_phase = PH_GO_IDLE;
                end
            end
            OP_COMPLETE: begin
                n_phase = PH_IDLE;
                case (r_phase)
                    PH_GO_IDLE: begin
                        if (i_item.command_error) begin
                            n_clock = 1'b0;
                            n_power = 1'b0;
                            res     = RES_FAIL;
                        end else begin
                            cmd     = f_cmd(CMD_SEND_IF, IF_COND_ARG, RSP_R7);
                            n_phase = PH_IF_COND;
                        end
                    end
                    PH_IF_COND: begin
                        // echo check picks the high-capacity request bit
                        if (i_item.command_error
                            || i_item.response_word0[7:0] != IF_COND_ECHO) begin
                            n_req_ocr = r_host_window & ~OCR_HCS;
                        end else begin
                            n_req_ocr = r_host_window | OCR_HCS;
                        end
                        n_tries = r_retry_limit;
                        if (r_retry_limit == 8'd0) begin
                            n_power = 1'b0;
                            res     = RES_FAIL;
                        end else begin
                            cmd     = f_cmd(CMD_APP_CMD, 32'd0, RSP_R1);
                            n_phase = PH_APP_CMD;
                        end
                    end
                    PH_APP_CMD, PH_OP_COND: begin
                        if (r_phase == PH_APP_CMD && !i_item.command_error) begin
                            cmd     = f_cmd(CMD_SD_OP_COND, r_req_ocr, RSP_R3);
                            n_phase = PH_OP_COND;
                        end else if (r_phase == PH_OP_COND && !i_item.command_error
                                     && i_item.response_word0[31]) begin
                            n_high_cap = i_item.response_word0[30];
                            cmd        = f_cmd(CMD_ALL_SEND_CID, 32'd0, RSP_R2);
                            n_phase    = PH_CID;
                        end else begin
                            // another attempt, or give up when the budget is gone
                            n_tries = tries_dec;
                            if (tries_dec == 8'd0) begin
                                n_power = 1'b0;
                                res     = RES_FAIL;
                            end else begin
                                cmd     = f_cmd(CMD_APP_CMD, 32'd0, RSP_R1);
                                n_phase = PH_APP_CMD;
                            end
                        end
                    end
                    PH_CID: begin
                        if (i_item.command_error) begin
                            n_clock = 1'b0;
                            n_power = 1'b0;
                            res     = RES_FAIL;
                        end else begin
                            cmd     = f_cmd(CMD_SEND_RCA, 32'd0, RSP_R6);
                            n_phase = PH_RCA;
                        end
                    end
                    PH_RCA: begin
                        if (i_item.command_error) begin
                            n_clock = 1'b0;
                            n_power = 1'b0;
                            res     = RES_FAIL;
                        end else begin
                            n_rca      = i_item.response_word0[31:16];
                            n_selected = 1'b0;
                            n_inserted = 1'b1;
                            cmd        = f_cmd(CMD_SEND_CSD,
                                               {i_item.response_word0[31:16], 16'd0}, RSP_R2);
                            n_phase    = PH_CSD;
                        end
                    end
                    PH_CSD: begin
                        if (i_item.command_error) begin
                            n_power = 1'b0;
                            res     = RES_FAIL;
                        end else begin
                            n_sectors = csd.sectors;
                            n_timeout = csd.timeout_ns;
                            cmd       = f_cmd(CMD_SELECT, {r_rca, 16'd0}, RSP_R1B);
                            n_phase   = PH_SEL_INIT;
                        end
                    end
                    PH_SEL_INIT: begin
                        // a failed select here is tolerated
                        if (!i_item.command_error) begin
                            n_selected = 1'b1;
                        end
                        cmd     = f_cmd(CMD_BLOCKLEN, 32'(BLOCK_BYTES), RSP_R1);
                        n_phase = PH_BLOCKLEN;
                    end
                    PH_BLOCKLEN: begin
                        if (i_item.command_error) begin
                            n_inserted = 1'b0;
                            n_selected = 1'b0;
                            n_clock    = 1'b0;
                            n_power    = 1'b0;
                            res        = RES_FAIL;
                        end
                    end
                    PH_SEL_READ: begin
                        if (i_item.command_error) begin
                            res = RES_FAIL;
                        end else begin
                            n_selected = 1'b1;
                            if (r_card_unacked) begin
                                res = RES_FAIL;
                            end else begin
                                cmd     = f_read_cmd(r_pend_start, r_pend_count, r_high_cap);
                                n_phase = PH_READ;
                            end
                        end
                    end
                    PH_READ: begin
                        res = i_item.command_error ? RES_FAIL : RES_OK;
                    end
                    default: begin
                        res = RES_FAIL;
                    end
                endcase
            end
            OP_READ: begin
                if (r_phase != PH_IDLE || !r_inserted) begin
                    res = RES_FAIL;
                end else begin
                    n_pend_start = i_item.block_start;
                    n_pend_count = i_item.block_count;
                    if (!r_selected) begin
                        cmd     = f_cmd(CMD_SELECT, {r_rca, 16'd0}, RSP_R1B);
                        n_phase = PH_SEL_READ;
                    end else if (r_card_unacked) begin
                        res = RES_FAIL;
                    end else begin
                        cmd     = f_read_cmd(i_item.block_start, i_item.block_count,
                                             r_high_cap);
                        n_phase = PH_READ;
                    end
                end
            end
            default: begin
                // new-card acknowledge
                if (r_card_unacked) begin
                    n_card_unacked = 1'b0;
                end else begin
                    res = RES_FAIL;
                end
            end
        endcase

        if (cmd.issue) begin
            res = RES_ISSUED;
        end

        o_result.cmd               = cmd;
        o_result.power_enable      = n_power;
        o_result.clock_enable      = n_clock;
        o_result.card_status       = !n_inserted ? CARD_NONE
                                   : (n_card_unacked ? CARD_NEW : CARD_INSERTED);
        o_result.result_code       = res;
        o_result.sector_count      = n_sectors;
        o_result.access_timeout_ns = n_timeout;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RST;
            r_host_window <= HOST_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[7:0];
                CFG_HOST_WINDOW: r_host_window <= i_cfg_data;
                default:         r_retry_limit <= r_retry_limit;
            endcase
        end
    end

    // card state, advanced once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_tries        <= '0;
            r_req_ocr      <= '0;
            r_high_cap     <= 1'b0;
            r_inserted     <= 1'b0;
            r_selected     <= 1'b0;
            r_card_unacked <= 1'b0;
            r_rca          <= '0;
            r_sectors      <= '0;
            r_timeout      <= '0;
            r_pend_start   <= '0;
            r_pend_count   <= '0;
            r_power        <= 1'b0;
            r_clock        <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_tries        <= n_tries;
            r_req_ocr      <= n_req_ocr;
            r_high_cap     <= n_high_cap;
            r_inserted     <= n_inserted;
            r_selected     <= n_selected;
            r_card_unacked <= n_card_unacked;
            r_rca          <= n_rca;
            r_sectors      <= n_sectors;
            r_timeout      <= n_timeout;
            r_pend_start   <= n_pend_start;
            r_pend_count   <= n_pend_count;
            r_power        <= n_power;
            r_clock        <= n_clock;
        end
    end

    // a read in flight always has a selected card
    `SDI_ASSERT_IMPL(a_read_selected, i_clk, i_rst_n, r_phase == PH_READ, r_selected)
    // an ACMD41 loop never runs with an empty retry budget
    `SDI_ASSERT_IMPL(a_tries_live, i_clk, i_rst_n,
        r_phase == PH_APP_CMD || r_phase == PH_OP_COND, r_tries != 8'd0)
    // a select for read only goes to an inserted, unselected card
    `SDI_ASSERT_IMPL(a_sel_read_card, i_clk, i_rst_n, r_phase == PH_SEL_READ,
        r_inserted && !r_selected)

endmodule

### test/sdi_tb_pkg.sv
// ----------------------------------------------------------------------------
// SD card sequencer scoreboard
// Predicts the result of every accepted event from a private copy of the
// sequencer state and checks the results that the block hands out, in order.
// ----------------------------------------------------------------------------
package sdi_tb_pkg;

    import sdi_pkg::*;

    // bring-up and read phases as the predictor tracks them
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_GO_IDLE,
        SEQ_IF_COND,
        SEQ_APP_CMD,
        SEQ_OP_COND,
        SEQ_CID,
        SEQ_RCA,
        SEQ_CSD,
        SEQ_SEL_INIT,
        SEQ_BLOCKLEN,
        SEQ_SEL_READ,
        SEQ_READ
    } t_seq_phase;

    // TAAC unit (ns) and value (times ten) for the CSD v1 timeout
    localparam int unsigned TAAC_UNIT [8] = '{1, 10, 100, 1000, 10000, 100000,
                                              1000000, 10000000};
    localparam int unsigned TAAC_VALUE [16] = '{1, 10, 12, 13, 15, 20, 25, 30,
                                                35, 40, 45, 50, 55, 60, 70, 80};

    class sdi_scoreboard;

        // configuration copy
        logic [7:0]  retry_limit;
        logic [31:0] host_window;

        // sequencer state copy
        t_seq_phase  phase;
        logic [7:0]  tries_left;
        logic [31:0] req_ocr;
        logic        high_cap;
        logic        inserted;
        logic        selected;
        logic        card_unacked;
        logic [15:0] rca;
        logic [31:0] cid_word;
        logic [35:0] sectors;
        logic [31:0] timeout_ns;
        logic [31:0] pend_start;
        logic [31:0] pend_count;
        logic        power_on;
        logic        clock_on;

        t_result     awaited_results [$];
        int unsigned errors;

        function new();
            retry_limit  = RETRY_LIMIT_RST;
            host_window  = HOST_WINDOW_RST;
            phase        = SEQ_IDLE;
            tries_left   = '0;
            req_ocr      = '0;
            high_cap     = 1'b0;
            inserted     = 1'b0;
            selected     = 1'b0;
            card_unacked = 1'b0;
            rca          = '0;
            cid_word     = '0;
            sectors      = '0;
            timeout_ns   = '0;
            pend_start   = '0;
            pend_count   = '0;
            power_on     = 1'b0;
            clock_on     = 1'b0;
            errors       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_RETRY_LIMIT) begin
                retry_limit = data[7:0];
            end else begin
                host_window = data;
            end
        endfunction

        function t_cmd make_cmd(logic [5:0] idx, logic [31:0] arg, logic [2:0] kind);
            t_cmd c;
            c       = '0;
            c.issue = 1'b1;
            c.index = idx;
            c.arg   = arg;
            c.kind  = kind;
            return c;
        endfunction

        // CMD18 for the stored request; byte-addressed cards take a byte offset
        function t_cmd read_cmd();
            t_cmd c;
            c       = make_cmd(CMD_READ_MULTI,
                               high_cap ? pend_start : 32'(pend_start << BLOCK_SHIFT), RSP_R1);
            c.rd    = 1'b1;
            c.bytes = 41'(pend_count) << BLOCK_SHIFT;
            phase   = SEQ_READ;
            return c;
        endfunction

        // one event through the sequencer: state update and the result it yields
        function t_result sequence_step(t_item it);
            t_result     r;
            logic [1:0]  res;
            t_seq_phase  was;
            logic [127:0] csd;
            logic [7:0]  taac;
            logic [11:0] c_size;
            logic [3:0]  rd_bl_len;
            logic [2:0]  c_mult;
            logic [63:0] wide;
            r   = '0;
            res = RES_OK;
            csd = {it.response_word3, it.response_word2, it.response_word1, it.response_word0};
            case (it.op)
                OP_DETECT: begin
                    // host reset, then restart bring-up if a card sits in the slot
                    power_on     = 1'b0;
                    clock_on     = 1'b0;
                    card_unacked = 1'b1;
                    phase        = SEQ_IDLE;
                    if (!it.card_present) begin
                        inserted = 1'b0;
                    end else begin
                        power_on = 1'b1;
                        clock_on = 1'b1;
                        r.cmd    = make_cmd(CMD_GO_IDLE, '0, RSP_NONE);
                        phase    = SEQ_GO_IDLE;
                    end
                end
                OP_COMPLETE: begin
                    was   = phase;
                    phase = SEQ_IDLE;
                    case (was)
                        SEQ_GO_IDLE: begin
                            if (it.command_error) begin
                                clock_on = 1'b0;
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end else begin
                                r.cmd = make_cmd(CMD_SEND_IF, IF_COND_ARG, RSP_R7);
                                phase = SEQ_IF_COND;
                            end
                        end
                        SEQ_IF_COND: begin
                            // echo match asks the card for high capacity
                            if (it.command_error || it.response_word0[7:0] != IF_COND_ECHO) begin
                                req_ocr = host_window & ~OCR_HCS;
                            end else begin
                                req_ocr = host_window | OCR_HCS;
                            end
                            tries_left = retry_limit;
                            if (tries_left == 0) begin
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end else begin
                                r.cmd = make_cmd(CMD_APP_CMD, '0, RSP_R1);
                                phase = SEQ_APP_CMD;
                            end
                        end
                        SEQ_APP_CMD, SEQ_OP_COND: begin
                            if (was == SEQ_APP_CMD && !it.command_error) begin
                                r.cmd = make_cmd(CMD_SD_OP_COND, req_ocr, RSP_R3);
                                phase = SEQ_OP_COND;
                            end else if (was == SEQ_OP_COND && !it.command_error &&
                                         it.response_word0[31]) begin
                                // power-up done; bit 30 tells the addressing mode
                                high_cap = it.response_word0[30];
                                r.cmd    = make_cmd(CMD_ALL_SEND_CID, '0, RSP_R2);
                                phase    = SEQ_CID;
                            end else begin
                                tries_left = tries_left - 8'd1;
                                if (tries_left == 0) begin
                                    power_on = 1'b0;
                                    res      = RES_FAIL;
                                end else begin
                                    r.cmd = make_cmd(CMD_APP_CMD, '0, RSP_R1);
                                    phase = SEQ_APP_CMD;
                                end
                            end
                        end
                        SEQ_CID: begin
                            if (it.command_error) begin
                                clock_on = 1'b0;
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end else begin
                                cid_word = it.response_word0;
                                r.cmd    = make_cmd(CMD_SEND_RCA, '0, RSP_R6);
                                phase    = SEQ_RCA;
                            end
                        end
                        SEQ_RCA: begin
                            if (it.command_error) begin
                                clock_on = 1'b0;
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end else begin
                                rca      = it.response_word0[31:16];
                                selected = 1'b0;
                                inserted = 1'b1;
                                r.cmd    = make_cmd(CMD_SEND_CSD, {rca, 16'h0000}, RSP_R2);
                                phase    = SEQ_CSD;
                            end
                        end
                        SEQ_CSD: begin
                            if (it.command_error) begin
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end else begin
                                taac = csd[111:104];
                                if (taac == TAAC_CSD_V2) begin
                                    // v2: 24-bit size in units of 512 KiB
                                    wide       = (64'(csd[63:40]) + 64'd1) << CSD_V2_SHIFT;
                                    timeout_ns = CSD_V2_TMO_NS;
                                end else begin
                                    // v1: size, multiplier and block length fields
                                    rd_bl_len  = csd[75:72];
                                    c_size     = {csd[65:64], csd[63:56], csd[55:54]};
                                    c_mult     = {csd[41:40], csd[39]};
                                    timeout_ns = TAAC_UNIT[taac[2:0]] * TAAC_VALUE[taac[6:3]]
                                                 / 32'd10;
                                    wide = ((64'(c_size) + 64'd1) * (64'd4 << c_mult))
                                           << rd_bl_len;
                                    wide = wide / 64'(BLOCK_BYTES);
                                end
                                sectors = wide[35:0];
                                r.cmd   = make_cmd(CMD_SELECT, {rca, 16'h0000}, RSP_R1B);
                                phase   = SEQ_SEL_INIT;
                            end
                        end
                        SEQ_SEL_INIT: begin
                            // a failed select here does not stop bring-up
                            if (!it.command_error) begin
                                selected = 1'b1;
                            end
                            r.cmd = make_cmd(CMD_BLOCKLEN, 32'(BLOCK_BYTES), RSP_R1);
                            phase = SEQ_BLOCKLEN;
                        end
                        SEQ_BLOCKLEN: begin
                            if (it.command_error) begin
                                inserted = 1'b0;
                                selected = 1'b0;
                                clock_on = 1'b0;
                                power_on = 1'b0;
                                res      = RES_FAIL;
                            end
                        end
                        SEQ_SEL_READ: begin
                            if (it.command_error) begin
                                res = RES_FAIL;
                            end else begin
                                selected = 1'b1;
                                if (card_unacked) begin
                                    res = RES_FAIL;
                                end else begin
                                    r.cmd = read_cmd();
                                end
                            end
                        end
                        SEQ_READ: begin
                            res = it.command_error ? RES_FAIL : RES_OK;
                        end
                        default: begin
                            // nothing outstanding
                            res = RES_FAIL;
                        end
                    endcase
                end
                OP_READ: begin
                    if (phase != SEQ_IDLE || !inserted) begin
                        res = RES_FAIL;
                    end else begin
                        pend_start = it.block_start;
                        pend_count = it.block_count;
                        if (!selected) begin
                            r.cmd = make_cmd(CMD_SELECT, {rca, 16'h0000}, RSP_R1B);
                            phase = SEQ_SEL_READ;
                        end else if (card_unacked) begin
                            res = RES_FAIL;
                        end else begin
                            r.cmd = read_cmd();
                        end
                    end
                end
                default: begin
                    if (card_unacked) begin
                        card_unacked = 1'b0;
                    end else begin
                        res = RES_FAIL;
                    end
                end
            endcase
            if (r.cmd.issue) begin
                res = RES_ISSUED;
            end
            r.power_enable      = power_on;
            r.clock_enable      = clock_on;
            r.card_status       = !inserted ? CARD_NONE
                                : (card_unacked ? CARD_NEW : CARD_INSERTED);
            r.result_code       = res;
            r.sector_count      = sectors;
            r.access_timeout_ns = timeout_ns;
            return r;
        endfunction

        // accepted event: queue its result
        function void note_event(t_item it);
            awaited_results.push_back(sequence_step(it));
        endfunction

        function int unsigned pending_count();
            return awaited_results.size();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
                errors++;
            end
        endfunction

        // accepted result: compare against the oldest prediction
        function void check_result(t_result seen);
            t_result want;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, actual %0h", $time, seen);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("issue_command", want.cmd.issue, seen.cmd.issue);
            compare_field("command_index", want.cmd.index, seen.cmd.index);
            compare_field("command_argument", want.cmd.arg, seen.cmd.arg);
            compare_field("response_kind", want.cmd.kind, seen.cmd.kind);
            compare_field("read_transfer", want.cmd.rd, seen.cmd.rd);
            compare_field("transfer_bytes", want.cmd.bytes, seen.cmd.bytes);
            compare_field("power_enable", want.power_enable, seen.power_enable);
            compare_field("clock_enable", want.clock_enable, seen.clock_enable);
            compare_field("card_status", want.card_status, seen.card_status);
            compare_field("result_code", want.result_code, seen.result_code);
            compare_field("sector_count", want.sector_count, seen.sector_count);
            compare_field("access_timeout_ns", want.access_timeout_ns,
                          seen.access_timeout_ns);
        endfunction

    endclass

endpackage

### test/tb.sv
// ----------------------------------------------------------------------------
// SD card sequencer testbench
// Directed bring-up and read events, then mostly well-formed random card
// sessions with errors and restarts mixed in, under several retry and voltage
// window settings, with random gaps and stalls on both channels. Every result
// is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;

    import sdi_pkg::*;
    import sdi_tb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_EVENTS = 225;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_op = '0;
    logic                  i_card_present = 1'b0;
    logic                  i_command_error = 1'b0;
    logic [31:0]           i_response_word0 = '0;
    logic [31:0]           i_response_word1 = '0;
    logic [31:0]           i_response_word2 = '0;
    logic [31:0]           i_response_word3 = '0;
    logic [31:0]           i_block_start = '0;
    logic [31:0]           i_block_count = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_issue_command;
    logic [5:0]            o_command_index;
    logic [31:0]           o_command_argument;
    logic [2:0]            o_response_kind;
    logic                  o_read_transfer;
    logic [40:0]           o_transfer_bytes;
    logic                  o_power_enable;
    logic                  o_clock_enable;
    logic [1:0]            o_card_status;
    logic [1:0]            o_result_code;
    logic [35:0]           o_sector_count;
    logic [31:0]           o_access_timeout_ns;

    // idle percentage for both sides and long receiver holds asked for
    int unsigned           idle_pct = 0;
    int unsigned           hold_requests = 0;

    sdi_scoreboard sb = new();

    sd_card_init_and_read_sequencer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_card_present      (i_card_present),
        .i_command_error     (i_command_error),
        .i_response_word0    (i_response_word0),
        .i_response_word1    (i_response_word1),
        .i_response_word2    (i_response_word2),
        .i_response_word3    (i_response_word3),
        .i_block_start       (i_block_start),
        .i_block_count       (i_block_count),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_issue_command     (o_issue_command),
        .o_command_index     (o_command_index),
        .o_command_argument  (o_command_argument),
        .o_response_kind     (o_response_kind),
        .o_read_transfer     (o_read_transfer),
        .o_transfer_bytes    (o_transfer_bytes),
        .o_power_enable      (o_power_enable),
        .o_clock_enable      (o_clock_enable),
        .o_card_status       (o_card_status),
        .o_result_code       (o_result_code),
        .o_sector_count      (o_sector_count),
        .o_access_timeout_ns (o_access_timeout_ns)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 4);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_item make_event(logic [1:0] op, logic present, logic err,
                                         logic [31:0] w0, logic [31:0] w1,
                                         logic [31:0] w2, logic [31:0] w3,
                                         logic [31:0] start, logic [31:0] count);
        t_item it;
        it.op             = op;
        it.card_present   = present;
        it.command_error  = err;
        it.response_word0 = w0;
        it.response_word1 = w1;
        it.response_word2 = w2;
        it.response_word3 = w3;
        it.block_start    = start;
        it.block_count    = count;
        return it;
    endfunction

    function automatic logic chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // next random event, shaped by where the predicted sequence stands
    function automatic t_item pick_event();
        t_item       it;
        int unsigned roll;
        it = make_event(OP_COMPLETE, 1'(chance(85)), 1'b0, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
        if (chance(3)) begin
            it.block_start = chance(50) ? '0 : '1;
            it.block_count = chance(50) ? '0 : '1;
        end
        roll = $urandom_range(0, 99);
        // noise: any event at all
        if (roll < 5) begin
            it.op = 2'($urandom_range(0, 3));
            return it;
        end
        // broken sequence: card yanked or reinserted
        if (roll < 7) begin
            it.op = OP_DETECT;
            return it;
        end
        case (sb.phase)
            SEQ_IDLE: begin
                if (!sb.inserted) begin
                    it.op = OP_DETECT;
                end else if (sb.card_unacked && chance(55)) begin
                    it.op = OP_ACK;
                end else if (chance(10)) begin
                    it.op = OP_DETECT;
                end else begin
                    it.op = OP_READ;
                end
            end
            SEQ_IF_COND: begin
                it.command_error = chance(10);
                if (chance(70)) begin
                    it.response_word0[7:0] = IF_COND_ECHO;
                end
            end
            SEQ_OP_COND: begin
                it.command_error       = chance(10);
                it.response_word0[31]  = chance(55);
            end
            SEQ_CSD: begin
                it.command_error = chance(5);
                if (chance(50)) begin
                    it.response_word3[15:8] = TAAC_CSD_V2;
                end
            end
            SEQ_GO_IDLE, SEQ_CID, SEQ_RCA: begin
                it.command_error = chance(5);
            end
            default: begin
                it.command_error = chance(12);
            end
        endcase
        return it;
    endfunction

    // offer one event and hold it until the block takes it
    task automatic send_event(input t_item it);
        i_in_valid       <= 1'b1;
        i_op             <= it.op;
        i_card_present   <= it.card_present;
        i_command_error  <= it.command_error;
        i_response_word0 <= it.response_word0;
        i_response_word1 <= it.response_word1;
        i_response_word2 <= it.response_word2;
        i_response_word3 <= it.response_word3;
        i_block_start    <= it.block_start;
        i_block_count    <= it.block_count;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(it);
    endtask

    task automatic sender_gap();
        if (idle_pct != 0 && chance(idle_pct)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // stop offering until every outstanding result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: check each transfer, stall in bursts or on a long hold
    initial begin : result_side
        t_result     seen;
        int unsigned stall_left;
        int unsigned holds_done;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen.cmd.issue         = o_issue_command;
                seen.cmd.index         = o_command_index;
                seen.cmd.arg           = o_command_argument;
                seen.cmd.kind          = o_response_kind;
                seen.cmd.rd            = o_read_transfer;
                seen.cmd.bytes         = o_transfer_bytes;
                seen.power_enable      = o_power_enable;
                seen.clock_enable      = o_clock_enable;
                seen.card_status       = o_card_status;
                seen.result_code       = o_result_code;
                seen.sector_count      = o_sector_count;
                seen.access_timeout_ns = o_access_timeout_ns;
                sb.check_result(seen);
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if (hold_requests != holds_done) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end else if (idle_pct != 0 && chance(idle_pct / 3)) begin
                stall_left = $urandom_range(1, 17);
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    initial begin : stimulus
        t_item       directed [$];
        int unsigned pct [6];
        repeat (6) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        idle_pct <= 15;
        @(posedge i_clk);

        // idle-state failures, no-card detect, full bring-up at extremes, reads
        directed.push_back(make_event(OP_COMPLETE, 1'b1, 1'b1, '1, '1, '1, '1, '1, '1));
        directed.push_back(make_event(OP_READ, 1'b1, 1'b0, '0, '0, '0, '0, '1, '1));
        directed.push_back(make_event(OP_ACK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_DETECT, 1'b0, 1'b1, '1, '1, '1, '1, '1, '1));
        directed.push_back(make_event(OP_ACK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_DETECT, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, IF_COND_ARG, '0, '0, '0,
                                      '0, '0));
        // app command failure retries, then a busy power-up answer
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, 32'hC0FF_8000, '0, '0, '0,
                                      '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '1, '1, '1, '1, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, 32'hFFFF_0000, '0, '0, '0,
                                      '0, '0));
        // v2 CSD with the largest size field
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '1, '0, 32'h0000_0E00,
                                      '0, '0));
        // select failure during bring-up is ignored
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_READ, 1'b0, 1'b0, '0, '0, '0, '0, '1, '1));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_ACK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_READ, 1'b0, 1'b0, '0, '0, '0, '0, '1, '1));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_READ, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_event(OP_COMPLETE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
        foreach (directed[k]) begin
            sender_gap();
            send_event(directed[k]);
        end

        // random sessions under several settings; the last one runs flat out
        pct = '{12, 25, 6, 0, 15, 0};
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(CFG_RETRY_LIMIT, {24'($urandom), 8'd1});
                    write_reg(CFG_HOST_WINDOW, '0);
                end
                1: begin
                    write_reg(CFG_RETRY_LIMIT, {24'($urandom), 8'd255});
                    write_reg(CFG_HOST_WINDOW, '1);
                end
                2: begin
                    // no ACMD41 attempts at all: power-up fails right after CMD8
                    write_reg(CFG_RETRY_LIMIT, {24'($urandom), 8'd0});
                    write_reg(CFG_HOST_WINDOW, $urandom);
                end
                3: begin
                    write_reg(CFG_RETRY_LIMIT, {24'($urandom), 8'd3});
                    write_reg(CFG_HOST_WINDOW, $urandom | OCR_HCS);
                end
                4: begin
                    write_reg(CFG_RETRY_LIMIT, {24'($urandom), 8'($urandom_range(1, 8))});
                    write_reg(CFG_HOST_WINDOW, $urandom & ~OCR_HCS);
                end
                default: begin
                    write_reg(CFG_RETRY_LIMIT, {24'd0, RETRY_LIMIT_RST});
                    write_reg(CFG_HOST_WINDOW, HOST_WINDOW_RST);
                end
            endcase
            idle_pct <= pct[p];
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                // long receiver hold while events keep coming
                if (p == 1 && n == 60) begin
                    hold_requests <= hold_requests + 1;
                end
                sender_gap();
                send_event(pick_event());
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
